// ----- hdl/b2d_pkg.sv -----
// shared types and constants for the binary to decimal ascii converter
// no dependencies; imported by b2d_pipe and binary_to_decimal_ascii_core
package b2d_pkg;

  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int DIFF_W     = 35;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digits_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = IDX_W'(NUM_DIGITS - 1);

  // ascii '0' sits at 0b110000, so a digit below ten only fills the low nibble
  localparam logic [1:0] ASCII_DIGIT_TOP = 2'b11;

  // decimal place weights, most significant first
  localparam logic [31:0] WEIGHT [NUM_DIGITS] = '{
    32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000, 32'd100000,
    32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
  };

  // c times the weight of place k, wide enough for nine billion
  function automatic logic [DIFF_W-1:0] multiple(input int unsigned k, input int unsigned c);
    logic [63:0] p;
    p = 64'(c) * 64'(WEIGHT[k]);
    return p[DIFF_W-1:0];
  endfunction

  // what the last pipeline stage hands to the character serializer
  typedef struct packed {
    logic    valid;
    logic    started;
    idx_t    first;
    digits_t digits;
  } pipe_out_t;

endpackage

// ----- hdl/b2d_pipe.sv -----
// digit extraction pipeline: one register stage per decimal place
// depends on b2d_pkg
module b2d_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       number,
  input  logic              take,
  output b2d_pkg::pipe_out_t result
);
  import b2d_pkg::*;

  logic                    v_q     [NUM_DIGITS];
  logic [31:0]             rest_q  [NUM_DIGITS-1];
  digits_t                 dig_q   [NUM_DIGITS];
  logic                    start_q [NUM_DIGITS];
  idx_t                    first_q [NUM_DIGITS];
  logic [NUM_DIGITS:0]     adv;

  // a stage moves when it is empty or the one after it moves
  assign adv[NUM_DIGITS] = take;
  assign in_stall        = !adv[0];

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_stage
    logic [31:0] rest_in;
    digits_t     dig_in;
    logic        start_in;
    idx_t        first_in;
    logic        v_in;
    logic [31:0] rest_next;
    digit_t      d;
    digits_t     dig_next;
    logic [DIFF_W-1:0] diff;

    if (k == 0) begin : g_head
      assign rest_in  = number;
      assign dig_in   = '0;
      assign start_in = 1'b0;
      assign first_in = '0;
      assign v_in     = in_valid;
    end else begin : g_body
      assign rest_in  = rest_q[k-1];
      assign dig_in   = dig_q[k-1];
      assign start_in = start_q[k-1];
      assign first_in = first_q[k-1];
      assign v_in     = v_q[k-1];
    end

    assign adv[k] = !v_q[k] || adv[k+1];

    // largest multiple of the place weight that fits, all compares in parallel
    always_comb begin
      d         = '0;
      rest_next = rest_in;
      diff      = '0;
      for (int unsigned c = 1; c < 10; c++) begin
        diff = {{(DIFF_W-32){1'b0}}, rest_in} - multiple(k, c);
        if (!diff[DIFF_W-1]) begin
          d         = DIGIT_W'(c);
          rest_next = diff[31:0];
        end
      end
      dig_next    = dig_in;
      dig_next[k] = d;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_in;
      end
    end

    // payload, no reset
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        dig_q[k]    <= dig_next;
        start_q[k]  <= start_in || (d != '0);
        first_q[k]  <= (!start_in && (d != '0)) ? IDX_W'(k) : first_in;
      end
    end

    if (k < NUM_DIGITS - 1) begin : g_rest
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          rest_q[k] <= rest_next;
        end
      end
    end
  end

  assign result.valid   = v_q[NUM_DIGITS-1];
  assign result.started = start_q[NUM_DIGITS-1];
  assign result.first   = first_q[NUM_DIGITS-1];
  assign result.digits  = dig_q[NUM_DIGITS-1];

endmodule

// ----- hdl/binary_to_decimal_ascii_core.sv -----
// binary to decimal ascii converter, top level: digit pipeline plus serializer
// depends on b2d_pkg and b2d_pipe
// path: a request passes the ten digit stages, then the serializer register
// throughput: one request per cycle enters the ten-stage digit pipeline
// unless in_stall holds it; the serializer emits one character per cycle
// unless out_stall holds it; numbers (1 to 10 digits) run gapless when ready
// reset: synchronous, clears pipeline and serializer valid bits only
module binary_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  digit_char,
  output logic        last
);
  import b2d_pkg::*;

  pipe_out_t p_out;
  logic      take;
  logic      out_fire;

  logic      ser_busy;
  digits_t   ser_dig;
  idx_t      ser_idx;

  b2d_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .number   (number),
    .take     (take),
    .result   (p_out)
  );

  // output side driven straight from the serializer registers
  assign out_valid  = ser_busy;
  assign last       = (ser_idx == LAST_IDX);
  assign digit_char = {ASCII_DIGIT_TOP, ser_dig[ser_idx]};
  assign out_fire   = out_valid && !out_stall;

  // next number loads when idle or as the current one's final character leaves
  assign take = !ser_busy || (out_fire && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_busy <= 1'b0;
    end else if (take) begin
      ser_busy <= p_out.valid;
    end
  end

  // start at the leading nonzero digit, or the ones place for zero
  always_ff @(posedge clk) begin
    if (take) begin
      ser_dig <= p_out.digits;
      ser_idx <= p_out.started ? p_out.first : LAST_IDX;
    end else if (out_fire) begin
      ser_idx <= ser_idx + 1'b1;
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= 6'd48 && digit_char <= 6'd57))
    else $error("digit character out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ser_busy |-> (ser_idx <= LAST_IDX))
    else $error("serializer index past the ones place");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last) |=> out_valid)
    else $error("number ended without its last character");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (p_out.valid && !take))
    else $error("input stalled while pipeline can advance");

endmodule
